// File: rtl/slpd_pkg.sv
// Shared types and constants for the sync/length packet deframer.
// No dependencies; used by slpd_core and sync_length_packet_deframer.
package slpd_pkg;

  localparam int unsigned LEN_W   = 32;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // deframer phases
  localparam logic [1:0] PH_HUNT1 = 2'd0;
  localparam logic [1:0] PH_HUNT2 = 2'd1;
  localparam logic [1:0] PH_LEN   = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BODY  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_REJ1  = 2'd2;
  localparam logic [1:0] KIND_REJ2  = 2'd3;

  // register indexes (paddr[2])
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h5A;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hA5;

  typedef struct packed {
    logic [1:0]       phase;
    logic [1:0]       lcnt;
    logic [LEN_W-1:0] cnt;
  } dfr_state_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    logic [7:0] body_byte;
    logic       last;
  } dfr_result_t;

endpackage

// File: rtl/slpd_core.sv
// Next-state and result logic for one received word of the deframer.
// Purely combinational; depends on slpd_pkg.
module slpd_core (
  input  logic [7:0]           in_byte,
  input  logic [7:0]           sync_first,
  input  logic [7:0]           sync_second,
  input  slpd_pkg::dfr_state_t st,
  output slpd_pkg::dfr_state_t st_nxt,
  output slpd_pkg::dfr_result_t res
);

  logic [slpd_pkg::LEN_W-1:0] len_acc;
  logic [slpd_pkg::LEN_W-1:0] cnt_dec;

  always_comb begin
    len_acc = st.cnt;
    case (st.lcnt)
      2'd0:    len_acc[7:0]   = in_byte;
      2'd1:    len_acc[15:8]  = in_byte;
      2'd2:    len_acc[23:16] = in_byte;
      default: len_acc[31:24] = in_byte;
    endcase
  end

  assign cnt_dec = st.cnt - slpd_pkg::LEN_W'(1);

  always_comb begin
    st_nxt        = st;
    res.emit      = 1'b0;
    res.kind      = slpd_pkg::KIND_BODY;
    res.body_byte = 8'd0;
    res.last      = 1'b0;
    unique case (st.phase)
      slpd_pkg::PH_HUNT1: begin
        if (in_byte == sync_first) begin
          st_nxt.phase = slpd_pkg::PH_HUNT2;
        end else begin
          res.emit = 1'b1;
          res.kind = slpd_pkg::KIND_REJ1;
        end
      end
      slpd_pkg::PH_HUNT2: begin
        if (in_byte == sync_second) begin
          st_nxt.phase = slpd_pkg::PH_LEN;
          st_nxt.lcnt  = 2'd0;
          st_nxt.cnt   = '0;
        end else begin
          st_nxt.phase = slpd_pkg::PH_HUNT1;
          res.emit     = 1'b1;
          res.kind     = slpd_pkg::KIND_REJ2;
        end
      end
      slpd_pkg::PH_LEN: begin
        st_nxt.cnt = len_acc;
        if (st.lcnt != 2'd3) begin
          st_nxt.lcnt = st.lcnt + 2'd1;
        end else begin
          st_nxt.lcnt = 2'd0;
          if (len_acc == '0) begin
            st_nxt.phase = slpd_pkg::PH_HUNT1;
            res.emit     = 1'b1;
            res.kind     = slpd_pkg::KIND_EMPTY;
            res.last     = 1'b1;
          end else begin
            st_nxt.phase = slpd_pkg::PH_BODY;
          end
        end
      end
      default: begin
        st_nxt.cnt    = cnt_dec;
        res.emit      = 1'b1;
        res.kind      = slpd_pkg::KIND_BODY;
        res.body_byte = in_byte;
        res.last      = (cnt_dec == '0);
        if (cnt_dec == '0) begin
          st_nxt.phase = slpd_pkg::PH_HUNT1;
        end
      end
    endcase
  end

endmodule

// File: rtl/sync_length_packet_deframer.sv
// Top level of the sync/length packet deframer: word registers, state, APB registers.
// Depends on slpd_pkg and slpd_core.
//
// Takes one received byte per word and sustains one word per clock while the output
// is not stalled. A word is registered on entry, decoded by a single pass of
// next-state logic and its result (if any) is written to the output register when
// the output is free; a stalled output holds one result while one more word
// waits in the entry register. Frames are two sync bytes, a 32-bit little-endian
// body length and the body; length bytes give no result, a zero length gives one
// empty-packet result, a bad sync byte gives a reject status. Sync values are set
// over APB at 0x0 (first) and 0x4 (second) and should be changed only when idle.
module sync_length_packet_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output logic [7:0]                   out_body_byte,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slpd_pkg::PADDR_W-1:0] paddr,
  input  logic [slpd_pkg::PDATA_W-1:0] pwdata,
  output logic [slpd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  logic [7:0]            sync_first_r;
  logic [7:0]            sync_second_r;
  logic                  in_vld_r;
  logic [7:0]            in_byte_r;
  logic                  out_vld_r;
  logic [1:0]            out_kind_r;
  logic [7:0]            out_body_r;
  logic                  out_last_r;
  slpd_pkg::dfr_state_t  st_r;
  slpd_pkg::dfr_state_t  st_nxt;
  slpd_pkg::dfr_result_t res;
  logic                  proc_fire;
  logic                  out_free;
  logic                  apb_wr;

  // APB
  assign pready = 1'b1;
  assign apb_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= slpd_pkg::SYNC_FIRST_RST;
      sync_second_r <= slpd_pkg::SYNC_SECOND_RST;
    end else if (apb_wr) begin
      unique case (paddr[2])
        slpd_pkg::REG_SYNC_FIRST:  sync_first_r  <= pwdata[7:0];
        slpd_pkg::REG_SYNC_SECOND: sync_second_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      slpd_pkg::REG_SYNC_FIRST:  prdata = {24'd0, sync_first_r};
      slpd_pkg::REG_SYNC_SECOND: prdata = {24'd0, sync_second_r};
      default:                   prdata = '0;
    endcase
  end

  // word flow
  assign out_free  = !out_vld_r || out_ready;
  assign proc_fire = in_vld_r && out_free;
  assign in_ready  = !in_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  slpd_core u_core (
    .in_byte     (in_byte_r),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .st          (st_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= slpd_pkg::PH_HUNT1;
      st_r.lcnt  <= 2'd0;
      st_r.cnt   <= '0;
    end else if (proc_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= proc_fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && out_free) begin
      out_kind_r <= res.kind;
      out_body_r <= res.body_byte;
      out_last_r <= res.last;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_kind      = out_kind_r;
  assign out_body_byte = out_body_r;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  a_body_emits: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && st_r.phase == slpd_pkg::PH_BODY |=> out_valid)
    else $error("body word gave no result");

  a_body_cnt_nz: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == slpd_pkg::PH_BODY |-> st_r.cnt != '0)
    else $error("in body with zero bytes remaining");

  a_lcnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.lcnt != 2'd0 |-> st_r.phase == slpd_pkg::PH_LEN)
    else $error("length count set outside length phase");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == slpd_pkg::KIND_EMPTY |-> out_last && out_body_byte == 8'd0)
    else $error("empty packet result malformed");

  a_rej_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == slpd_pkg::KIND_REJ1 || out_kind == slpd_pkg::KIND_REJ2)
    |-> !out_last && out_body_byte == 8'd0)
    else $error("reject result carries data");
`endif

endmodule
